/* rtl/vector_move_towards3_defines.svh */
`ifndef VECTOR_MOVE_TOWARDS3_DEFINES_SVH
`define VECTOR_MOVE_TOWARDS3_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VMT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define VMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/vmt_pkg.sv */
package vmt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_AXES = 3;

    typedef struct packed {
        logic en;
        logic valid;
    } vmt_ctrl_t;

endpackage

/* rtl/vmt_if.sv */
interface vmt_in_if import vmt_pkg::*; #(parameter int W = COORD_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] start_z;
    logic signed [W-1:0] target_x;
    logic signed [W-1:0] target_y;
    logic signed [W-1:0] target_z;
    logic signed [W-1:0] step_limit;

    modport source (
        output valid, start_x, start_y, start_z, target_x, target_y, target_z, step_limit,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, target_x, target_y, target_z, step_limit,
        output ready
    );
endinterface

interface vmt_out_if import vmt_pkg::*; #(parameter int W = COORD_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [W-1:0] next_x;
    logic signed [W-1:0] next_y;
    logic signed [W-1:0] next_z;

    modport source (
        output valid, next_x, next_y, next_z,
        input  ready
    );
    modport sink (
        input  valid, next_x, next_y, next_z,
        output ready
    );
endinterface

/* rtl/vmt_sqrt.sv */
module vmt_sqrt import vmt_pkg::*; #(
    parameter int W  = COORD_WIDTH_DEF,
    parameter int PW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  vmt_ctrl_t         ctrl,
    input  logic [2*W+3:0]    sum,
    input  logic [PW-1:0]     side_in,
    output logic              valid_out,
    output logic [W+1:0]      root,
    output logic [PW-1:0]     side_out
);

    localparam int SW   = 2*W+4;
    localparam int RW   = W+2;
    localparam int REMW = RW+2;

    logic [REMW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [SW-1:0]   sh_reg   [RW];
    logic [PW-1:0]   side_reg [RW];
    logic            v_reg    [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [REMW-1:0] rem_p;
        logic [RW-1:0]   root_p;
        logic [SW-1:0]   sh_p;
        logic [PW-1:0]   side_p;
        logic            v_p;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign sh_p   = sum;
            assign side_p = side_in;
            assign v_p    = ctrl.valid;
        end
        else begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign sh_p   = sh_reg[k-1];
            assign side_p = side_reg[k-1];
            assign v_p    = v_reg[k-1];
        end

        // one root bit per stage
        assign rem_sh = {rem_p[REMW-3:0], sh_p[SW-1 -: 2]};
        assign trial  = {root_p, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (ctrl.en)
            begin
                v_reg[k] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.en)
            begin
                rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k] <= {root_p[RW-2:0], ge};
                sh_reg[k]   <= {sh_p[SW-3:0], 2'b00};
                side_reg[k] <= side_p;
            end
        end
    end

    assign valid_out = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

/* rtl/vmt_div.sv */
module vmt_div import vmt_pkg::*; #(
    parameter int W  = COORD_WIDTH_DEF,
    parameter int PW = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  vmt_ctrl_t                      ctrl,
    input  logic [NUM_AXES-1:0][2*W:0]     num,
    input  logic [W+1:0]                   den,
    input  logic [PW-1:0]                  side_in,
    output logic                           valid_out,
    output logic [NUM_AXES-1:0][W-1:0]     quot,
    output logic [PW-1:0]                  side_out
);

    localparam int DW  = W+2;
    localparam int RMW = DW+1;

    logic [NUM_AXES-1:0][RMW-1:0] rem_reg  [W];
    logic [NUM_AXES-1:0][W-1:0]   lo_reg   [W];
    logic [NUM_AXES-1:0][W-1:0]   q_reg    [W];
    logic [DW-1:0]                den_reg  [W];
    logic [PW-1:0]                side_reg [W];
    logic                         v_reg    [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [NUM_AXES-1:0][RMW-1:0] rem_p;
        logic [NUM_AXES-1:0][W-1:0]   lo_p;
        logic [NUM_AXES-1:0][W-1:0]   q_p;
        logic [DW-1:0]                den_p;
        logic [PW-1:0]                side_p;
        logic                         v_p;
        logic [NUM_AXES-1:0][RMW-1:0] rem_next;
        logic [NUM_AXES-1:0][W-1:0]   q_next;

        if (k == 0) begin : g_first
            for (genvar j = 0; j < NUM_AXES; j++) begin : g_lane
                assign rem_p[j] = {2'b00, num[j][2*W:W]};
                assign lo_p[j]  = num[j][W-1:0];
                assign q_p[j]   = '0;
            end
            assign den_p  = den;
            assign side_p = side_in;
            assign v_p    = ctrl.valid;
        end
        else begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign lo_p   = lo_reg[k-1];
            assign q_p    = q_reg[k-1];
            assign den_p  = den_reg[k-1];
            assign side_p = side_reg[k-1];
            assign v_p    = v_reg[k-1];
        end

        // one quotient bit per stage and lane
        for (genvar j = 0; j < NUM_AXES; j++) begin : g_step
            logic [RMW-1:0] rem_sh;
            logic           ge;
            assign rem_sh      = {rem_p[j][RMW-2:0], lo_p[j][W-1]};
            assign ge          = rem_sh >= {1'b0, den_p};
            assign rem_next[j] = ge ? rem_sh - {1'b0, den_p} : rem_sh;
            assign q_next[j]   = {q_p[j][W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (ctrl.en)
            begin
                v_reg[k] <= v_p;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.en)
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                den_reg[k]  <= den_p;
                side_reg[k] <= side_p;
                for (int j = 0; j < NUM_AXES; j++)
                begin
                    lo_reg[k][j] <= {lo_p[j][W-2:0], 1'b0};
                end
            end
        end
    end

    assign valid_out = v_reg[W-1];
    assign quot      = q_reg[W-1];
    assign side_out  = side_reg[W-1];

endmodule

/* rtl/vector_move_towards3.sv */
// throughput: one word per cycle unless the output stalls, set by the bit-per-stage
// root and quotient pipelines
// a stall at the output freezes every stage; nothing is dropped or repeated
// reset clears all stage valid bits and the output valid; data registers are not reset
module vector_move_towards3 import vmt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vmt_in_if.sink     din,
    vmt_out_if.source  dout
);

`include "vector_move_towards3_defines.svh"

    localparam int W     = COORD_WIDTH;
    localparam int SW    = 2*W+4;
    localparam int RW    = W+2;
    localparam int PW_SQ = 10*W+6;
    localparam int PW_DV = 6*W+4;
    localparam logic signed [W+1:0] SAT_HI = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SAT_LO = {3'b111, {(W-1){1'b0}}};
    localparam logic [W-1:0]        Q_MAX  = {1'b1, {(W-1){1'b0}}};

    typedef logic [NUM_AXES-1:0][W-1:0] vec_t;
    typedef logic [NUM_AXES-1:0][W:0]   mag_t;

    logic      en;
    vmt_ctrl_t ctrl;
    vmt_ctrl_t ctrl_dv;

    vec_t s_in;
    vec_t t_in;

    // stage 1: differences
    logic   v1_reg;
    vec_t   s1_reg, t1_reg;
    mag_t   dmag1_reg;
    logic [NUM_AXES-1:0] dneg1_reg;
    logic [W-1:0] lim1_reg;
    mag_t   dmag_next;
    logic [NUM_AXES-1:0] dneg_next;

    // stage 2: squares
    logic   v2_reg;
    vec_t   s2_reg, t2_reg;
    mag_t   dmag2_reg;
    logic [NUM_AXES-1:0] dneg2_reg;
    logic [W-1:0] lim2_reg;
    logic [NUM_AXES-1:0][2*W+1:0] sq2_reg;

    // stage 3: sum of squares
    logic   v3_reg;
    logic [SW-1:0] sum3_reg;
    logic [PW_SQ-1:0] side3_reg;

    // root pipeline
    logic   sq_v;
    logic [RW-1:0] sq_root;
    logic [PW_SQ-1:0] sq_side;
    vec_t   sq_s, sq_t;
    mag_t   sq_dmag;
    logic [NUM_AXES-1:0] sq_dneg;
    logic [W-1:0] sq_lim;

    // stage m: decision and products
    logic   vm_reg;
    logic [RW-1:0] lenm_reg;
    logic [NUM_AXES-1:0][2*W:0] prodm_reg;
    logic [PW_DV-1:0] sidem_reg;
    logic   move_next;
    logic   lim_neg;
    logic [W-1:0] lim_mag;

    // quotient pipeline
    logic   dv_v;
    vec_t   dv_q;
    logic [PW_DV-1:0] dv_side;
    vec_t   dv_s, dv_t;
    logic [NUM_AXES-1:0] dv_neg;
    logic   dv_move;

    // output word
    logic   o_v_reg;
    vec_t   o_reg;
    vec_t   o_next;

    assign en            = !o_v_reg || dout.ready;
    assign din.ready     = en;
    assign ctrl.en       = en;
    assign ctrl.valid    = v3_reg;
    assign ctrl_dv.en    = en;
    assign ctrl_dv.valid = vm_reg;

    assign s_in = {din.start_z, din.start_y, din.start_x};
    assign t_in = {din.target_z, din.target_y, din.target_x};

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            logic [W:0] d;
            d            = {t_in[i][W-1], t_in[i]} - {s_in[i][W-1], s_in[i]};
            dneg_next[i] = d[W];
            dmag_next[i] = d[W] ? -d : d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vm_reg  <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= din.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            vm_reg  <= sq_v;
            o_v_reg <= dv_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= s_in;
            t1_reg    <= t_in;
            dmag1_reg <= dmag_next;
            dneg1_reg <= dneg_next;
            lim1_reg  <= din.step_limit;

            s2_reg    <= s1_reg;
            t2_reg    <= t1_reg;
            dmag2_reg <= dmag1_reg;
            dneg2_reg <= dneg1_reg;
            lim2_reg  <= lim1_reg;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sq2_reg[i] <= (2*W+2)'(dmag1_reg[i]) * (2*W+2)'(dmag1_reg[i]);
            end

            sum3_reg  <= SW'(sq2_reg[0]) + SW'(sq2_reg[1]) + SW'(sq2_reg[2]);
            side3_reg <= {s2_reg, t2_reg, dmag2_reg, dneg2_reg, lim2_reg};
        end
    end

    vmt_sqrt #(
        .W  (W),
        .PW (PW_SQ)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sum       (sum3_reg),
        .side_in   (side3_reg),
        .valid_out (sq_v),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    assign {sq_s, sq_t, sq_dmag, sq_dneg, sq_lim} = sq_side;

    assign lim_neg   = sq_lim[W-1];
    assign lim_mag   = lim_neg ? -sq_lim : sq_lim;
    assign move_next = (sq_root != '0) &&
                       ($signed({1'b0, sq_root}) > $signed({{3{sq_lim[W-1]}}, sq_lim}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lenm_reg  <= sq_root;
            sidem_reg <= {sq_s, sq_t, sq_dneg ^ {NUM_AXES{lim_neg}}, move_next};
            for (int i = 0; i < NUM_AXES; i++)
            begin
                prodm_reg[i] <= (2*W+1)'(sq_dmag[i]) * (2*W+1)'(lim_mag);
            end
        end
    end

    vmt_div #(
        .W  (W),
        .PW (PW_DV)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_dv),
        .num       (prodm_reg),
        .den       (lenm_reg),
        .side_in   (sidem_reg),
        .valid_out (dv_v),
        .quot      (dv_q),
        .side_out  (dv_side)
    );

    assign {dv_s, dv_t, dv_neg, dv_move} = dv_side;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            logic signed [W+1:0] acc;
            acc = dv_neg[i] ? $signed({{2{dv_s[i][W-1]}}, dv_s[i]}) - $signed({2'b00, dv_q[i]})
                            : $signed({{2{dv_s[i][W-1]}}, dv_s[i]}) + $signed({2'b00, dv_q[i]});
            if (!dv_move)
            begin
                o_next[i] = dv_t[i];
            end
            else if (acc > SAT_HI)
            begin
                o_next[i] = SAT_HI[W-1:0];
            end
            else if (acc < SAT_LO)
            begin
                o_next[i] = SAT_LO[W-1:0];
            end
            else
            begin
                o_next[i] = acc[W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg <= o_next;
        end
    end

    assign dout.valid  = o_v_reg;
    assign dout.next_x = o_reg[0];
    assign dout.next_y = o_reg[1];
    assign dout.next_z = o_reg[2];

    // a stalled pipeline must not shift
    `VMT_ASSERT_NEXT(a_stall_freeze, !en, $stable(sq_v) && $stable(dv_v) && $stable(vm_reg), "pipeline moved while stalled")

    // the length is never below any component, so no quotient exceeds the limit
    `VMT_ASSERT_IMP(a_quot_bound, dv_v && dv_move, (dv_q[0] <= Q_MAX) && (dv_q[1] <= Q_MAX) && (dv_q[2] <= Q_MAX), "quotient above limit magnitude")

endmodule

/* sim/vmt_checker.sv */
module vmt_checker import vmt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    vmt_in_if    din,
    vmt_out_if   dout,
    output int   fails,
    output int   pending
);

    typedef struct {
        logic signed [COORD_WIDTH_DEF-1:0] x;
        logic signed [COORD_WIDTH_DEF-1:0] y;
        logic signed [COORD_WIDTH_DEF-1:0] z;
    } point_t;

    point_t expected_points[$];

    localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH_DEF - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint step_axis(input longint s, input longint d, input longint lim,
                                         input logic [63:0] len);
        logic [127:0] q;
        longint v;
        q = (128'(magnitude(d)) * magnitude(lim)) / len;
        if (q > (128'd1 << 62))
            q = 128'd1 << 62;
        v = ((d < 0) != (lim < 0)) ? s - longint'(q[63:0]) : s + longint'(q[63:0]);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return v;
    endfunction

    function automatic point_t move_towards(input longint sx, input longint sy,
                                            input longint sz, input longint tx,
                                            input longint ty, input longint tz,
                                            input longint lim);
        longint dx, dy, dz;
        logic [127:0] dist_sq;
        logic [63:0] len, cand;
        point_t p;
        dx = tx - sx;
        dy = ty - sy;
        dz = tz - sz;
        dist_sq = 128'(magnitude(dx)) * magnitude(dx) + 128'(magnitude(dy)) * magnitude(dy)
                + 128'(magnitude(dz)) * magnitude(dz);
        len = 0;
        for (int b = 40; b >= 0; b--)
        begin
            cand = len | (64'd1 << b);
            if (128'(cand) * cand <= dist_sq)
                len = cand;
        end
        if (len == 0 || longint'(len) <= lim)
        begin
            p.x = tx;
            p.y = ty;
            p.z = tz;
        end
        else
        begin
            p.x = step_axis(sx, dx, lim, len);
            p.y = step_axis(sy, dy, lim, len);
            p.z = step_axis(sz, dz, lim, len);
        end
        return p;
    endfunction

    assign pending = expected_points.size();

    initial fails = 0;

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n)
        begin
            if (din.valid && din.ready)
                expected_points.push_back(move_towards(din.start_x, din.start_y, din.start_z,
                    din.target_x, din.target_y, din.target_z, din.step_limit));
            if (dout.valid && dout.ready)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected word %h %h %h", $time,
                             dout.next_x, dout.next_y, dout.next_z);
                    fails++;
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (dout.next_x !== e.x)
                    begin
                        $display("%0t: next_x expected %h actual %h", $time, e.x, dout.next_x);
                        fails++;
                    end
                    if (dout.next_y !== e.y)
                    begin
                        $display("%0t: next_y expected %h actual %h", $time, e.y, dout.next_y);
                        fails++;
                    end
                    if (dout.next_z !== e.z)
                    begin
                        $display("%0t: next_z expected %h actual %h", $time, e.z, dout.next_z);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

/* sim/tb_top.sv */
module tb_top;
    import vmt_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    int   fails;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_cycles = 0;
    int   cycle_count = 0;

    localparam int CYCLE_LIMIT = 2000000;

    vmt_in_if  din ();
    vmt_out_if dout ();

    vector_move_towards3 dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din.sink),
        .dout  (dout.source)
    );

    vmt_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din),
        .dout    (dout),
        .fails   (fails),
        .pending (pending)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side back-pressure, with one long hold-off
    initial
    begin
        dout.ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                dout.ready <= 0;
                hold_cycles--;
            end
            else
                dout.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sz, input logic [31:0] tx,
                             input logic [31:0] ty, input logic [31:0] tz,
                             input logic [31:0] lim);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            din.valid <= 0;
            @(posedge clk);
        end
        din.valid      <= 1;
        din.start_x    <= sx;
        din.start_y    <= sy;
        din.start_z    <= sz;
        din.target_x   <= tx;
        din.target_y   <= ty;
        din.target_z   <= tz;
        din.step_limit <= lim;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] near(input logic [31:0] v);
        return v + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endfunction

    task automatic send_random();
        logic [31:0] sx, sy, sz, tx, ty, tz, lim;
        sx = $urandom;
        sy = $urandom;
        sz = $urandom;
        lim = $urandom;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                tx = near(sx);
                ty = near(sy);
                tz = near(sz);
                lim = $urandom_range(0, 1 << 21) - (1 << 19);
            end
            2:
            begin
                tx = $urandom;
                ty = $urandom;
                tz = $urandom;
                lim = $urandom_range(0, 1 << 30);
            end
            3:
            begin
                tx = sx;
                ty = sy;
                tz = sz;
            end
            4:
            begin
                tx = near(sx);
                ty = sy;
                tz = near(sz);
                lim = -$urandom_range(0, 1 << 24);
            end
            default:
            begin
                tx = $urandom;
                ty = $urandom;
                tz = $urandom;
            end
        endcase
        send_word(sx, sy, sz, tx, ty, tz, lim);
    endtask

    initial
    begin
        int idle_set[4];
        int stall_set[4];
        idle_set  = '{0, 58, 0, 23};
        stall_set = '{0, 0, 58, 23};
        din.valid = 0;
        din.start_x = 0;
        din.start_y = 0;
        din.start_z = 0;
        din.target_x = 0;
        din.target_y = 0;
        din.target_z = 0;
        din.step_limit = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // zero length, limits at both ends, moving away
        send_word(0, 0, 0, 0, 0, 0, 0);
        send_word(32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000);
        send_word(0, 0, 0, 32'h00030000, 32'h00040000, 0, 32'h00050000);
        send_word(0, 0, 0, 32'h00030000, 32'h00040000, 0, 32'h00010000);
        send_word(0, 0, 0, 32'h00030000, 32'h00040000, 0, 32'hffff0000);
        send_word(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_word(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h00010000);
        send_word(32'h7ffff000, 0, 0, 32'h7ffff001, 0, 0, 32'h80000000);
        send_word(32'h80000fff, 0, 0, 32'h80000ffe, 0, 0, 32'h80000000);
        send_word(1, 2, 3, 4, 5, 6, 32'h7fffffff);
        send_word(0, 0, 0, 0, 0, 1, 0);
        send_word(0, 0, 0, 0, 0, 1, 32'hffffffff);
        send_word(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f,
                  32'hedcba987, 32'h65432110, 32'hf0f0f0f0, 32'h00100000);
        send_word(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 1);
        send_word(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'hc0000000);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            if (ph == 2)
                hold_cycles = 400;
            for (int n = 0; n < 325; n++)
                send_random();
        end
        din.valid <= 0;
        recv_stall_pct = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
